// ===== rtl/core/multi_channel_led_blinker_core_macros.svh =====
// Assertion macros for the LED blinker core checker.
// Pulled in by the checker file with an include; no other dependencies.
`ifndef MULTI_CHANNEL_LED_BLINKER_CORE_MACROS_SVH
`define MULTI_CHANNEL_LED_BLINKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCLB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mclb: implication check failed");

// Next-cycle implication, disabled during reset.
`define MCLB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mclb: next-cycle check failed");

`endif

// ===== rtl/core/mclb_pkg.sv =====
// Types and constants shared by the LED blinker core, its channel unit and checker.
// No dependencies.
`default_nettype none

package mclb_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned PinW  = 2;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_STEADY = 2'd1,
    FUNC_FLASH  = 2'd2
  } mclb_func_e;

  typedef struct packed {
    logic             tick;
    logic             steady;
    logic             flash;
    logic             on_off;
    logic [TickW-1:0] on_ticks;
    logic [TickW-1:0] off_ticks;
  } mclb_ctl_t;

  typedef struct packed {
    logic            accepted;
    logic [PinW-1:0] pin_levels;
  } mclb_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/mclb_chan.sv =====
// One blinker channel: flash state, countdown and stored durations.
// Depends on mclb_pkg.
`default_nettype none

module mclb_chan
  import mclb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire mclb_ctl_t ctl_i,
  output logic           lit_nxt_o
);

  logic             flashing_q, flashing_d;
  logic             lit_q, lit_d;
  logic [TickW-1:0] remaining_q, remaining_d;
  logic [TickW-1:0] stored_on_q, stored_on_d;
  logic [TickW-1:0] stored_off_q, stored_off_d;

  always_comb begin
    flashing_d   = flashing_q;
    lit_d        = lit_q;
    remaining_d  = remaining_q;
    stored_on_d  = stored_on_q;
    stored_off_d = stored_off_q;
    if (ctl_i.tick && flashing_q) begin
      if (remaining_q <= TickW'(1)) begin
        lit_d       = ~lit_q;
        remaining_d = lit_q ? stored_off_q : stored_on_q;
      end else begin
        remaining_d = remaining_q - TickW'(1);
      end
    end else if (ctl_i.steady) begin
      flashing_d = 1'b0;
      lit_d      = ctl_i.on_off;
    end else if (ctl_i.flash) begin
      flashing_d = ctl_i.on_off;
      lit_d      = ctl_i.on_off;
      if (ctl_i.on_off) begin
        stored_on_d  = ctl_i.on_ticks;
        stored_off_d = ctl_i.off_ticks;
        remaining_d  = ctl_i.on_ticks;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flashing_q   <= 1'b0;
      lit_q        <= 1'b0;
      remaining_q  <= '0;
      stored_on_q  <= '0;
      stored_off_q <= '0;
    end else begin
      flashing_q   <= flashing_d;
      lit_q        <= lit_d;
      remaining_q  <= remaining_d;
      stored_on_q  <= stored_on_d;
      stored_off_q <= stored_off_d;
    end
  end

  assign lit_nxt_o = lit_d;

endmodule

`default_nettype wire

// ===== rtl/core/multi_channel_led_blinker_core.sv =====
// Multi-channel LED blinker core: command decode, channel array, result buffer.
// Depends on mclb_pkg and mclb_chan.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one beat per item: a tick
//   (func 0), a steady on/off command (func 1) or a flash command (func 2).
//   Each beat yields exactly one result beat on out_valid_o/out_ready_i with
//   accepted_o and pin_levels_o (pin levels after the item is applied).
//   Config channel (cfg_valid_i/cfg_ready_o) writes led_active_level; it is
//   always ready and should only be written while no result is pending.
//   Results are registered in the result buffer before they reach the output.
//   Throughput: 1 item per cycle while in_ready_o is high; all channel
//   updates are done in the cycle of acceptance by per-channel registers
//   feeding a 2-entry result buffer. Stall: when out_ready_i is low the
//   buffer still takes one more item; in_ready_o drops only when both
//   entries are full. Reset: all channels dark and not flashing,
//   led_active_level = 1, result buffer empty.
`default_nettype none

module multi_channel_led_blinker_core
  import mclb_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       func_i,
  input  wire logic [1:0]       channel_i,
  input  wire logic             on_off_i,
  input  wire logic [TickW-1:0] on_ticks_i,
  input  wire logic [TickW-1:0] off_ticks_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  accepted_o,
  output logic [PinW-1:0]       pin_levels_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_data_i
);

  logic                level_q;
  logic                in_fire, out_fire;
  logic                chan_ok, dur_ok;
  logic                is_tick, is_steady, is_flash, cmd_ok;
  logic [CHANNELS-1:0] lit_nxt;
  logic [PinW-1:0]     pin_d;
  mclb_res_t           res_new;
  mclb_res_t           slot0_q, slot1_q;
  logic [1:0]          count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
    end else if (cfg_valid_i) begin
      level_q <= cfg_data_i;
    end
  end

  assign chan_ok = {30'b0, channel_i} < CHANNELS;
  assign dur_ok  = !(on_off_i && ((on_ticks_i == '0) || (off_ticks_i == '0)));

  always_comb begin
    is_tick   = 1'b0;
    is_steady = 1'b0;
    is_flash  = 1'b0;
    cmd_ok    = 1'b0;
    unique case (func_i)
      FUNC_TICK: begin
        is_tick = 1'b1;
        cmd_ok  = 1'b1;
      end
      FUNC_STEADY: begin
        is_steady = chan_ok;
        cmd_ok    = chan_ok;
      end
      FUNC_FLASH: begin
        is_flash = chan_ok && dur_ok;
        cmd_ok   = chan_ok && dur_ok;
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic      sel;
    mclb_ctl_t ctl;

    assign sel           = ({30'b0, channel_i} == c);
    assign ctl.tick      = in_fire && is_tick;
    assign ctl.steady    = in_fire && is_steady && sel;
    assign ctl.flash     = in_fire && is_flash && sel;
    assign ctl.on_off    = on_off_i;
    assign ctl.on_ticks  = on_ticks_i;
    assign ctl.off_ticks = off_ticks_i;

    mclb_chan u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .lit_nxt_o (lit_nxt[c])
    );
  end

  for (genvar b = 0; b < PinW; b++) begin : g_pin
    if (b < CHANNELS) begin : g_on
      assign pin_d[b] = lit_nxt[b] ~^ level_q;
    end else begin : g_off
      assign pin_d[b] = 1'b0;
    end
  end

  assign res_new.accepted   = cmd_ok;
  assign res_new.pin_levels = pin_d;

  // two-entry result buffer, slot0 is the head
  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_q + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !out_fire) begin
      if (count_q == 2'd0) begin
        slot0_q <= res_new;
      end else begin
        slot1_q <= res_new;
      end
    end else if (out_fire && !in_fire) begin
      slot0_q <= slot1_q;
    end else if (in_fire && out_fire) begin
      if (count_q == 2'd1) begin
        slot0_q <= res_new;
      end else begin
        slot0_q <= slot1_q;
        slot1_q <= res_new;
      end
    end
  end

  assign accepted_o   = slot0_q.accepted;
  assign pin_levels_o = slot0_q.pin_levels;

endmodule

`default_nettype wire

// ===== rtl/core/mclb_core_chk.sv =====
// Port-level checker for the LED blinker core, bound to the top level.
// Depends on mclb_pkg and multi_channel_led_blinker_core_macros.svh.
`default_nettype none

`include "multi_channel_led_blinker_core_macros.svh"

module mclb_core_chk
  import mclb_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire logic [1:0]      func_i,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire logic            accepted_o,
  input wire logic [PinW-1:0] pin_levels_o
);

  logic in_beat;
  logic empty_beat;
  logic out_stall;
  logic tick_beat;
  logic bad_beat;
  logic out_same;

  assign in_beat    = in_valid_i && in_ready_o;
  assign empty_beat = in_beat && !out_valid_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign tick_beat  = empty_beat && (func_i == FUNC_TICK);
  assign bad_beat   = empty_beat && (func_i != FUNC_TICK) && (func_i != FUNC_STEADY)
                      && (func_i != FUNC_FLASH);

  `MCLB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)
  `MCLB_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_stall, $stable({accepted_o, pin_levels_o}))
  `MCLB_ASSERT_NXT(a_tick_ok, clk_i, rst_ni, tick_beat, out_valid_o && accepted_o)
  `MCLB_ASSERT_NXT(a_bad_func, clk_i, rst_ni, bad_beat, out_valid_o && !accepted_o)

endmodule

bind multi_channel_led_blinker_core mclb_core_chk u_mclb_core_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .func_i       (func_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .accepted_o   (accepted_o),
  .pin_levels_o (pin_levels_o)
);

`default_nettype wire
